// ===== src/window_pattern_histogram_assert.svh =====
// ---------------------------------------------------------------------------
// window pattern histogram assertion macros
// shared property forms for the block's concurrent checks
// ---------------------------------------------------------------------------
`ifndef WINDOW_PATTERN_HISTOGRAM_ASSERT_SVH
`define WINDOW_PATTERN_HISTOGRAM_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define WPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/wph_pkg.sv =====
// ---------------------------------------------------------------------------
// wph_pkg
// shared constants, codes and request types of the window pattern histogram
// ---------------------------------------------------------------------------
package wph_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COUNT_BITS = 20;

    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int PIXEL_BITS   = 32;
    localparam int OP_BITS      = 2;
    localparam int CODE_BITS    = 9;
    localparam int COORD_BITS   = 10;
    localparam int BIN_OUT_BITS = 20;
    localparam int HIST_DEPTH   = 512;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_RAW  = $clog2(MAX_DIM + 1);
    localparam int DIM_BITS = (DIM_RAW > CFG_BITS) ? DIM_RAW : CFG_BITS;
    localparam int MIN_DIM  = 3;

    localparam int SWEEP_DEPTH = (MAX_WIDTH > HIST_DEPTH) ? MAX_WIDTH : HIST_DEPTH;
    localparam int SWEEP_BITS  = $clog2(SWEEP_DEPTH);

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_BITS = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_BITS      = FIFO_LVL_BITS + 1;

    localparam logic [PIXEL_BITS-1:0] WHITE_ARGB     = 32'hFFFF_FFFF;
    localparam logic [CODE_BITS-1:0]  NEIGH_MASK     = 9'h1EF;
    localparam int                    CAND_NEIGHBORS = 2;

    localparam logic [CFG_BITS-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_BITS-1:0] RST_FRAME_HEIGHT = 11'd480;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'd1;

    typedef enum logic [OP_BITS-1:0] {
        OP_PIXEL = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        logic [OP_BITS-1:0]    operation;
        logic [PIXEL_BITS-1:0] pixel_argb;
        logic [CODE_BITS-1:0]  bin_index;
    } t_in_item;

    typedef struct packed {
        logic                    window_valid;
        logic [COORD_BITS-1:0]   center_x;
        logic [COORD_BITS-1:0]   center_y;
        logic [CODE_BITS-1:0]    pattern_code;
        logic                    is_candidate;
        logic [BIN_OUT_BITS-1:0] bin_count;
    } t_out_item;

    typedef struct packed {
        logic [CFG_BITS-1:0] frame_width;
        logic [CFG_BITS-1:0] frame_height;
    } t_cfg;

    // window stage to histogram stage
    typedef struct packed {
        logic                  valid;
        logic [OP_BITS-1:0]    op;
        logic                  window_valid;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [CODE_BITS-1:0]  pattern_code;
        logic                  is_candidate;
        logic [CODE_BITS-1:0]  addr;
    } t_hist_req;

    // memory clearing pass, driven by the histogram stage
    typedef struct packed {
        logic                  active;
        logic                  row_en;
        logic [SWEEP_BITS-1:0] idx;
    } t_sweep;

endpackage

// ===== src/window_pattern_histogram.sv =====
// ---------------------------------------------------------------------------
// window_pattern_histogram
// binary 3x3 neighborhood pattern histogram over a raster pixel stream
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake                  payload
//   -------  ---  -------------------------  ---------------------------
//   in       in   i_in_valid / o_in_stall     i_in_item  (t_in_item)
//   out      out  o_out_valid / i_out_stall   o_out_item (t_out_item)
//   cfg      in   i_cfg_we                    i_cfg_index, i_cfg_data
//
// one request per clock sustained while the output does not stall and no
// clear or clearing pass holds the input; each result passes in order through
// the window stage, the histogram stage and the result queue
// the histogram read-modify-write holds that rate through a one-deep bypass
// reset starts a clearing pass over line store and histogram, and a clear
// request starts a pass over the histogram only; no request is taken
// during either pass
// a four-entry result queue absorbs output stalls; input stalls once queue
// plus pipeline would fill it
// ---------------------------------------------------------------------------
`include "window_pattern_histogram_assert.svh"

module window_pattern_histogram (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  wph_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output wph_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [wph_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [wph_pkg::CFG_BITS-1:0]        i_cfg_data
);

    wph_pkg::t_cfg                     r_cfg;
    logic                              r_clr_pend;

    logic                              w_accept;
    wph_pkg::t_hist_req                w_req;
    wph_pkg::t_sweep                   w_sweep;
    wph_pkg::t_out_item                w_res;
    logic                              w_push, w_s2_valid, w_clear_done;
    logic [wph_pkg::FIFO_LVL_BITS-1:0] w_level;
    logic [wph_pkg::OCC_BITS-1:0]      w_occupancy;

    // queue entries plus requests still in the window and histogram stages
    assign w_occupancy = wph_pkg::OCC_BITS'(w_level)
                       + wph_pkg::OCC_BITS'(w_req.valid)
                       + wph_pkg::OCC_BITS'(w_s2_valid);

    // a clear holds the input until its clearing pass has run
    assign o_in_stall = r_clr_pend || w_sweep.active
                     || (32'(w_occupancy) >= wph_pkg::FIFO_DEPTH);
    assign w_accept   = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= wph_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height <= wph_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wph_pkg::CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                wph_pkg::CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clear pending from acceptance until it reaches the histogram stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_pend <= 1'b0;
        end else if (w_accept && (i_in_item.operation == wph_pkg::OP_CLEAR)) begin
            r_clr_pend <= 1'b1;
        end else if (w_clear_done) begin
            r_clr_pend <= 1'b0;
        end
    end

    // position, line store and window shift register
    wph_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .i_sweep  (w_sweep),
        .o_req    (w_req)
    );

    // histogram bins and clearing pass
    wph_hist u_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .o_push       (w_push),
        .o_res        (w_res),
        .o_s2_valid   (w_s2_valid),
        .o_clear_done (w_clear_done),
        .o_sweep      (w_sweep)
    );

    // result queue facing the output channel
    wph_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_item),
        .o_level (w_level)
    );

    // queue plus pipeline never exceeds the queue depth
    `WPH_ASSERT_IMP(a_credit, i_clk, i_rst_n, 1'b1, (32'(w_occupancy) <= wph_pkg::FIFO_DEPTH), "result credit overrun")
    // no push into a full queue
    `WPH_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, (32'(w_level) == wph_pkg::FIFO_DEPTH), (!w_push || (o_out_valid && !i_out_stall)), "result queue overflow")
    // clearing pass blocks the input
    `WPH_ASSERT_IMP(a_sweep_stall, i_clk, i_rst_n, w_sweep.active, o_in_stall, "request taken during clearing pass")
    // an accepted clear locks the input on the next cycle
    `WPH_ASSERT_NXT(a_clear_lock, i_clk, i_rst_n, (w_accept && (i_in_item.operation == wph_pkg::OP_CLEAR)), o_in_stall, "input open right after clear")

endmodule

// ===== src/wph_window.sv =====
// ---------------------------------------------------------------------------
// wph_window
// raster position, line store memory and 3x3 window shift register
// ---------------------------------------------------------------------------
module wph_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  wph_pkg::t_in_item  i_item,
    input  wph_pkg::t_cfg      i_cfg,
    input  wph_pkg::t_sweep    i_sweep,
    output wph_pkg::t_hist_req o_req
);

    typedef struct packed {
        logic                           valid;
        logic [wph_pkg::OP_BITS-1:0]    op;
        logic [wph_pkg::COL_BITS-1:0]   x;
        logic [wph_pkg::ROW_BITS-1:0]   y;
        logic                           fg;
        logic [wph_pkg::CODE_BITS-1:0]  bin;
    } t_s1;

    function automatic logic [wph_pkg::DIM_BITS-1:0] clamp_dim(
        input logic [wph_pkg::CFG_BITS-1:0] v,
        input logic [wph_pkg::DIM_BITS-1:0] hi
    );
        logic [wph_pkg::DIM_BITS-1:0] ve;
        ve = wph_pkg::DIM_BITS'(v);
        if (ve < wph_pkg::DIM_BITS'(wph_pkg::MIN_DIM)) begin
            return wph_pkg::DIM_BITS'(wph_pkg::MIN_DIM);
        end
        if (ve > hi) begin
            return hi;
        end
        return ve;
    endfunction

    logic [1:0] r_row_mem [wph_pkg::MAX_WIDTH];
    logic [1:0] r_row_rd;

    logic [wph_pkg::COL_BITS-1:0]  r_col, n_col;
    logic [wph_pkg::ROW_BITS-1:0]  r_row, n_row;
    logic [wph_pkg::CODE_BITS-1:0] r_win;
    t_s1                           r_s1;

    logic [wph_pkg::DIM_BITS-1:0]  w_wdim, w_hdim, w_col_inc, w_row_inc;
    logic [2:0]                    w_stack;
    logic [wph_pkg::CODE_BITS-1:0] w_new_win;
    logic                          w_s1_pixel, w_win_ok;
    logic [31:0]                   w_cx, w_cy;

    assign w_wdim    = clamp_dim(i_cfg.frame_width, wph_pkg::DIM_BITS'(wph_pkg::MAX_WIDTH));
    assign w_hdim    = clamp_dim(i_cfg.frame_height, wph_pkg::DIM_BITS'(wph_pkg::MAX_HEIGHT));
    assign w_col_inc = wph_pkg::DIM_BITS'(r_col) + wph_pkg::DIM_BITS'(1);
    assign w_row_inc = wph_pkg::DIM_BITS'(r_row) + wph_pkg::DIM_BITS'(1);

    // next raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            unique case (i_item.operation)
                wph_pkg::OP_PIXEL: begin
                    if (w_col_inc >= w_wdim) begin
                        n_col = '0;
                        n_row = (w_row_inc >= w_hdim) ? '0 : w_row_inc[wph_pkg::ROW_BITS-1:0];
                    end else begin
                        n_col = w_col_inc[wph_pkg::COL_BITS-1:0];
                    end
                end
                wph_pkg::OP_CLEAR: begin
                    n_col = '0;
                    n_row = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_s1.valid <= i_accept;
        end
        if (i_accept) begin
            r_s1.op  <= i_item.operation;
            r_s1.x   <= r_col;
            r_s1.y   <= r_row;
            r_s1.fg  <= (i_item.pixel_argb != wph_pkg::WHITE_ARGB);
            r_s1.bin <= i_item.bin_index;
        end
    end

    // column stack: bit 0 two rows up, bit 1 one row up, bit 2 this row
    assign w_stack    = {r_s1.fg, r_row_rd[0], r_row_rd[1]};
    assign w_new_win  = {w_stack, r_win[wph_pkg::CODE_BITS-1:3]};
    assign w_s1_pixel = r_s1.valid && (r_s1.op == wph_pkg::OP_PIXEL);
    assign w_win_ok   = (r_s1.x >= wph_pkg::COL_BITS'(2)) && (r_s1.y >= wph_pkg::ROW_BITS'(2));

    // line store: read at the accept edge, written back from the window stage
    always_ff @(posedge i_clk) begin
        if (i_sweep.active) begin
            if (i_sweep.row_en && (32'(i_sweep.idx) < wph_pkg::MAX_WIDTH)) begin
                r_row_mem[i_sweep.idx[wph_pkg::COL_BITS-1:0]] <= '0;
            end
        end else if (w_s1_pixel) begin
            r_row_mem[r_s1.x] <= {r_row_rd[0], r_s1.fg};
        end
        if (i_accept) begin
            r_row_rd <= r_row_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (w_s1_pixel) begin
            r_win <= w_new_win;
        end else if (r_s1.valid && (r_s1.op == wph_pkg::OP_CLEAR)) begin
            r_win <= '0;
        end
    end

    assign w_cx = 32'(r_s1.x) - 32'd1;
    assign w_cy = 32'(r_s1.y) - 32'd1;

    always_comb begin
        o_req.valid        = r_s1.valid;
        o_req.op           = r_s1.op;
        o_req.window_valid = 1'b0;
        o_req.center_x     = '0;
        o_req.center_y     = '0;
        o_req.pattern_code = '0;
        o_req.is_candidate = 1'b0;
        o_req.addr         = (r_s1.op == wph_pkg::OP_READ) ? r_s1.bin : w_new_win;
        if (w_s1_pixel && w_win_ok) begin
            o_req.window_valid = 1'b1;
            o_req.center_x     = w_cx[wph_pkg::COORD_BITS-1:0];
            o_req.center_y     = w_cy[wph_pkg::COORD_BITS-1:0];
            o_req.pattern_code = w_new_win;
            o_req.is_candidate = w_new_win[4] &&
                ($countones(w_new_win & wph_pkg::NEIGH_MASK) == wph_pkg::CAND_NEIGHBORS);
        end
    end

endmodule

// ===== src/wph_hist.sv =====
// ---------------------------------------------------------------------------
// wph_hist
// histogram memory with read-modify-write, forwarding and clearing pass
// ---------------------------------------------------------------------------
module wph_hist (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wph_pkg::t_hist_req i_req,
    output logic               o_push,
    output wph_pkg::t_out_item o_res,
    output logic               o_s2_valid,
    output logic               o_clear_done,
    output wph_pkg::t_sweep    o_sweep
);

    localparam logic [wph_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [wph_pkg::COUNT_BITS-1:0] r_cnt_mem [wph_pkg::HIST_DEPTH];
    logic [wph_pkg::COUNT_BITS-1:0] r_rd_data;

    wph_pkg::t_hist_req             r_s2;
    logic                           r_fwd_valid;
    logic [wph_pkg::CODE_BITS-1:0]  r_fwd_addr;
    logic [wph_pkg::COUNT_BITS-1:0] r_fwd_data;

    logic                           r_sweeping;
    logic                           r_sweep_row;
    logic [wph_pkg::SWEEP_BITS-1:0] r_sweep_idx;

    logic [wph_pkg::COUNT_BITS-1:0] w_cur, w_next;
    logic                           w_wr_en, w_clear;
    logic [wph_pkg::SWEEP_BITS-1:0] w_sweep_last;
    logic [31:0]                    w_cur_ext;

    // last write bypasses the memory read that raced it
    assign w_cur   = (r_fwd_valid && (r_fwd_addr == r_s2.addr)) ? r_fwd_data : r_rd_data;
    assign w_next  = (w_cur == COUNT_MAX) ? w_cur : (w_cur + wph_pkg::COUNT_BITS'(1));
    assign w_wr_en = r_s2.valid && (r_s2.op == wph_pkg::OP_PIXEL) && r_s2.window_valid;
    assign w_clear = r_s2.valid && (r_s2.op == wph_pkg::OP_CLEAR);

    assign w_sweep_last = r_sweep_row ? wph_pkg::SWEEP_BITS'(wph_pkg::SWEEP_DEPTH - 1)
                                      : wph_pkg::SWEEP_BITS'(wph_pkg::HIST_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (r_sweeping) begin
            if (32'(r_sweep_idx) < wph_pkg::HIST_DEPTH) begin
                r_cnt_mem[r_sweep_idx[wph_pkg::CODE_BITS-1:0]] <= '0;
            end
        end else if (w_wr_en) begin
            r_cnt_mem[r_s2.addr] <= w_next;
        end
        r_rd_data <= r_cnt_mem[i_req.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_sweeping  <= 1'b1;
            r_sweep_row <= 1'b1;
            r_sweep_idx <= '0;
        end else begin
            r_s2.valid  <= i_req.valid;
            r_fwd_valid <= w_wr_en && !r_sweeping;
            if (w_clear) begin
                r_sweeping  <= 1'b1;
                r_sweep_row <= 1'b0;
                r_sweep_idx <= '0;
            end else if (r_sweeping) begin
                if (r_sweep_idx == w_sweep_last) begin
                    r_sweeping <= 1'b0;
                end else begin
                    r_sweep_idx <= r_sweep_idx + wph_pkg::SWEEP_BITS'(1);
                end
            end
        end
        r_s2.op           <= i_req.op;
        r_s2.window_valid <= i_req.window_valid;
        r_s2.center_x     <= i_req.center_x;
        r_s2.center_y     <= i_req.center_y;
        r_s2.pattern_code <= i_req.pattern_code;
        r_s2.is_candidate <= i_req.is_candidate;
        r_s2.addr         <= i_req.addr;
        r_fwd_addr        <= r_s2.addr;
        r_fwd_data        <= w_next;
    end

    assign w_cur_ext = 32'(w_cur);

    always_comb begin
        o_res.window_valid = r_s2.window_valid;
        o_res.center_x     = r_s2.center_x;
        o_res.center_y     = r_s2.center_y;
        o_res.pattern_code = r_s2.pattern_code;
        o_res.is_candidate = r_s2.is_candidate;
        o_res.bin_count    = (r_s2.op == wph_pkg::OP_READ)
                           ? w_cur_ext[wph_pkg::BIN_OUT_BITS-1:0] : '0;
    end

    assign o_push         = r_s2.valid;
    assign o_s2_valid     = r_s2.valid;
    assign o_clear_done   = w_clear;
    assign o_sweep.active = r_sweeping;
    assign o_sweep.row_en = r_sweep_row;
    assign o_sweep.idx    = r_sweep_idx;

endmodule

// ===== src/wph_res_fifo.sv =====
// ---------------------------------------------------------------------------
// wph_res_fifo
// small result queue between the pipeline and the output channel
// ---------------------------------------------------------------------------
module wph_res_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  wph_pkg::t_out_item               i_data,
    input  logic                             i_stall,
    output logic                             o_valid,
    output wph_pkg::t_out_item               o_data,
    output logic [wph_pkg::FIFO_LVL_BITS-1:0] o_level
);

    wph_pkg::t_out_item                r_data [wph_pkg::FIFO_DEPTH];
    logic [wph_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [wph_pkg::FIFO_LVL_BITS-1:0] r_level;
    logic                              w_pop;

    function automatic logic [wph_pkg::FIFO_PTR_BITS-1:0] ptr_inc(
        input logic [wph_pkg::FIFO_PTR_BITS-1:0] p
    );
        if (32'(p) == wph_pkg::FIFO_DEPTH - 1) begin
            return '0;
        end
        return p + wph_pkg::FIFO_PTR_BITS'(1);
    endfunction

    assign w_pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !w_pop) begin
                r_level <= r_level + wph_pkg::FIFO_LVL_BITS'(1);
            end else if (w_pop && !i_push) begin
                r_level <= r_level - wph_pkg::FIFO_LVL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_data  = r_data[r_rd_ptr];
    assign o_level = r_level;

endmodule

// ===== test/tb_window_pattern_histogram.sv =====
// ---------------------------------------------------------------------------
// tb_window_pattern_histogram
// self-checking bench for the 3x3 pattern histogram: a tracker class mirrors
// line stores, window and histogram, and compares every result in order;
// directed frames first, then random frames of random size
// ---------------------------------------------------------------------------
import wph_pkg::*;

// mirror of the block: predicts one result per accepted request
class histogram_tracker;
    localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;

    logic [CFG_BITS-1:0]  frame_w;
    logic [CFG_BITS-1:0]  frame_h;
    bit [1:0]             line_bits [MAX_WIDTH];
    bit [CODE_BITS-1:0]   window;
    int unsigned          col;
    int unsigned          row;
    int unsigned          counts [HIST_DEPTH];
    bit [CODE_BITS-1:0]   last_code;
    t_out_item            upcoming_results [$];
    int unsigned          errors;

    function new();
        frame_w   = RST_FRAME_WIDTH;
        frame_h   = RST_FRAME_HEIGHT;
        foreach (line_bits[i]) line_bits[i] = '0;
        foreach (counts[i]) counts[i] = 0;
        window    = '0;
        col       = 0;
        row       = 0;
        last_code = '0;
        errors    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        if (idx == CFG_FRAME_WIDTH) frame_w = data;
        else frame_h = data;
    endfunction

    // out-of-range sizes act as the nearest legal one
    function int unsigned bounded(logic [CFG_BITS-1:0] v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function void take_request(t_in_item req);
        t_out_item          res;
        int unsigned        w;
        int unsigned        h;
        bit                 fg;
        bit [1:0]           stored;
        bit [2:0]           stack;
        res = '0;
        case (req.operation)
            OP_READ: begin
                res.bin_count = counts[req.bin_index][BIN_OUT_BITS-1:0];
            end
            OP_CLEAR: begin
                foreach (counts[i]) counts[i] = 0;
                window = '0;
                col    = 0;
                row    = 0;
            end
            OP_PIXEL: begin
                w      = bounded(frame_w, MAX_WIDTH);
                h      = bounded(frame_h, MAX_HEIGHT);
                fg     = (req.pixel_argb != WHITE_ARGB);
                stored = line_bits[col];
                // column stack: bit 0 two rows up, bit 1 one row up, bit 2 this row
                stack  = {fg, stored[0], stored[1]};
                window = {stack, window[CODE_BITS-1:3]};
                line_bits[col] = {stored[0], fg};
                if (col >= 2 && row >= 2) begin
                    res.window_valid = 1'b1;
                    res.center_x     = COORD_BITS'(col - 1);
                    res.center_y     = COORD_BITS'(row - 1);
                    res.pattern_code = window;
                    res.is_candidate = window[4] &&
                        ($countones(window & NEIGH_MASK) == CAND_NEIGHBORS);
                    if (counts[window] < COUNT_MAX) counts[window]++;
                    last_code = window;
                end
                if (col + 1 >= w) begin
                    col = 0;
                    row = (row + 1 >= h) ? 0 : row + 1;
                end else begin
                    col++;
                end
            end
            default: ;
        endcase
        upcoming_results = {upcoming_results, res};
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void compare_result(t_out_item got);
        t_out_item want;
        if (upcoming_results.size() == 0) begin
            $display("%0t: result with no request pending, got %h", $time, got);
            errors++;
            return;
        end
        want = upcoming_results.pop_front();
        check_field("window_valid", want.window_valid, got.window_valid);
        check_field("center_x", want.center_x, got.center_x);
        check_field("center_y", want.center_y, got.center_y);
        check_field("pattern_code", want.pattern_code, got.pattern_code);
        check_field("is_candidate", want.is_candidate, got.is_candidate);
        check_field("bin_count", want.bin_count, got.bin_count);
    endfunction

    function int unsigned pending();
        return upcoming_results.size();
    endfunction
endclass

module tb_window_pattern_histogram;

    // operation code with no meaning, must return zeros
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    t_in_item                 i_in_item   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_item                o_out_item;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_BITS-1:0]      i_cfg_data  = '0;

    histogram_tracker tracker = new();

    bit          quiet       = 1'b0;  // no gaps and no output stalls while set
    int          stall_left  = 0;
    int unsigned cycle_count = 0;

    window_pattern_histogram i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // mostly short idle runs, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(8, 4);
        return $urandom_range(60, 20);
    endfunction

    // frame size: mostly small, some below the minimum, some far too large
    function automatic logic [CFG_BITS-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 15) return CFG_BITS'($urandom_range(2));
        if (r < 85) return CFG_BITS'($urandom_range(12, 3));
        return CFG_BITS'($urandom_range(2047));
    endfunction

    function automatic t_in_item request_of(logic [OP_BITS-1:0] op,
                                            logic [PIXEL_BITS-1:0] argb,
                                            logic [CODE_BITS-1:0] bin);
        t_in_item req;
        req.operation  = op;
        req.pixel_argb = argb;
        req.bin_index  = bin;
        return req;
    endfunction

    // output stall: runs of random length, each stalled or open at random
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left == 0) begin
            if ($urandom_range(1) == 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= pick_idle();
            end else begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(12, 1);
            end
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // sample at the falling edge: inputs and outputs are settled until the next
    // rising edge, which is where the result is taken
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            tracker.compare_result(o_out_item);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // present one request, hold it until taken, then note it
    task automatic send_request(t_in_item req);
        int gap;
        gap = (quiet || $urandom_range(1) == 0) ? 0 : pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(negedge i_clk);
        while (o_in_stall !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
        tracker.take_request(req);
    endtask

    // drop valid, wait for every pending result, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // both size registers on back-to-back edges
    task automatic write_frame(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        tracker.set_register(CFG_FRAME_WIDTH, w);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        tracker.set_register(CFG_FRAME_HEIGHT, h);
        i_cfg_we    <= 1'b0;
    endtask

    // random pixel stream with random content; ctrl_pct of the requests are
    // reads, clears or the unused code
    task automatic run_mix(int count, int density, int ctrl_pct);
        t_in_item req;
        int       n;
        int       r;
        for (n = 0; n < count; n++) begin
            req.operation  = OP_PIXEL;
            req.pixel_argb = $urandom;
            req.bin_index  = CODE_BITS'($urandom);
            if ($urandom_range(99) >= density) req.pixel_argb = WHITE_ARGB;
            if ($urandom_range(99) < ctrl_pct) begin
                r = $urandom_range(99);
                if (r < 65) begin
                    req.operation = OP_READ;
                    // half of the reads go to a bin that was just hit
                    if ($urandom_range(1) == 1) req.bin_index = tracker.last_code;
                end else if (r < 85) begin
                    req.operation = OP_CLEAR;
                end else begin
                    req.operation = OP_UNUSED;
                end
            end
            send_request(req);
        end
    endtask

    initial begin
        int k;
        int p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state: empty bin, unused code, one pixel at the reset size, a clear
        send_request(request_of(OP_READ, WHITE_ARGB, 9'h1FF));
        send_request(request_of(OP_UNUSED, 32'h0000_0000, 9'h1FF));
        send_request(request_of(OP_PIXEL, 32'h0000_0000, 9'h000));
        send_request(request_of(OP_CLEAR, WHITE_ARGB, 9'h000));
        settle();
        write_frame(11'd3, 11'd3);

        // smallest frame, all foreground, pixels black or just off white
        for (k = 0; k < 9; k++) begin
            send_request(request_of(OP_PIXEL,
                (k == 0) ? 32'h0000_0000 : ~(32'h1 << (k * 3)), 9'h000));
        end
        // vertical line through the centre: a segment candidate
        for (k = 0; k < 9; k++) begin
            send_request(request_of(OP_PIXEL,
                (k % 3 == 1) ? 32'h0000_0000 : WHITE_ARGB, 9'h000));
        end
        send_request(request_of(OP_READ, 32'h0000_0000, 9'h1FF));
        send_request(request_of(OP_READ, 32'h0000_0000, 9'h038));
        send_request(request_of(OP_READ, 32'h0000_0000, 9'h000));

        // random phases; without a clear the position carries over and the
        // new size takes effect mid-frame
        for (p = 0; p < 8; p++) begin
            settle();
            quiet = ($urandom_range(3) == 0);
            write_frame(pick_dim(), pick_dim());
            if ($urandom_range(1) == 1) begin
                send_request(request_of(OP_CLEAR, $urandom, CODE_BITS'($urandom)));
            end
            run_mix(110, $urandom_range(90, 10), 12);
        end
        quiet = 1'b0;

        settle();
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== window_pattern_histogram.f =====
+incdir+src
src/wph_pkg.sv
src/wph_window.sv
src/wph_hist.sv
src/wph_res_fifo.sv
src/window_pattern_histogram.sv
test/tb_window_pattern_histogram.sv
